[src/biq_pkg.sv]
// biq_pkg: shared types and constants for the biquad filter block
// no dependencies; imported by the top level and the datapath

package biq_pkg;

   // configuration register map
   localparam int NUM_REGS       = 5;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   // extra accumulator bits: five terms plus the rounding constant
   localparam int ACC_GUARD_BITS = 3;

endpackage : biq_pkg

[src/biq_mac.sv]
// biq_mac: direct form I multiply-accumulate with round and saturate
// depends on biq_pkg

module biq_mac #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  logic signed [SAMPLE_BITS-1:0] x,
   input  logic signed [SAMPLE_BITS-1:0] x1,
   input  logic signed [SAMPLE_BITS-1:0] x2,
   input  logic signed [SAMPLE_BITS-1:0] y1,
   input  logic signed [SAMPLE_BITS-1:0] y2,
   input  logic signed [COEF_BITS-1:0]   coef_b0,
   input  logic signed [COEF_BITS-1:0]   coef_b1,
   input  logic signed [COEF_BITS-1:0]   coef_b2,
   input  logic signed [COEF_BITS-1:0]   coef_a1,
   input  logic signed [COEF_BITS-1:0]   coef_a2,
   output logic signed [SAMPLE_BITS-1:0] y,
   output logic                          sat
);
   import biq_pkg::*;

   localparam int FRAC_BITS = COEF_BITS - 2;
   localparam int PROD_W    = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W     = PROD_W + ACC_GUARD_BITS;
   localparam int YW        = ACC_W - FRAC_BITS;

   localparam logic signed [ACC_W-1:0] RND =
      {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [ACC_W-1:0]  acc;
   logic signed [YW-1:0]     y_full;
   logic                     pos_ovf, neg_ovf;

   // five independent products, exact
   assign p_b0 = PROD_W'(coef_b0) * PROD_W'(x);
   assign p_b1 = PROD_W'(coef_b1) * PROD_W'(x1);
   assign p_b2 = PROD_W'(coef_b2) * PROD_W'(x2);
   assign p_a1 = PROD_W'(coef_a1) * PROD_W'(y1);
   assign p_a2 = PROD_W'(coef_a2) * PROD_W'(y2);

   assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
              - ACC_W'(p_a1) - ACC_W'(p_a2) + RND;

   // round half up then drop the fraction
   assign y_full = YW'(acc >>> FRAC_BITS);

   assign pos_ovf = !y_full[YW-1] && (|y_full[YW-2:SAMPLE_BITS-1]);
   assign neg_ovf =  y_full[YW-1] && !(&y_full[YW-2:SAMPLE_BITS-1]);

   always_comb begin
      if (pos_ovf) begin
         y = Y_MAX;
      end else if (neg_ovf) begin
         y = Y_MIN;
      end else begin
         y = y_full[SAMPLE_BITS-1:0];
      end
   end

   assign sat = pos_ovf || neg_ovf;

endmodule : biq_mac

[src/biquad_iir_filter_top.sv]
// biquad_iir_filter_top: biquad (direct form I) filter over planar channels
// depends on biq_pkg and biq_mac

// One sample transaction is taken every clock cycle unless a stalled output
// fills the compute stage, also when consecutive samples belong to the same
// channel; a result waits in an output register, so the input keeps accepting
// while one result is pending and one more is in flight. The figure is set by
// the history memory: one entry per channel holding x[n-1], x[n-2], y[n-1],
// y[n-2], read when a sample is taken and written back when the compute
// stage moves on, with the just-written history forwarded when the next
// sample hits the same channel. block_start clears that channel's history
// before filtering. Coefficients are signed Q2.(COEF_BITS-2), a1 and a2 are
// subtracted; the output is rounded half up and saturated, and rsp_saturated
// flags clipping. Write coefficients only while idle.

module biquad_iir_filter_top #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample input channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   input  logic                                  req_channel,
   input  logic                                  req_block_start,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   output logic                                  rsp_saturated,
   // coefficient write port
   input  logic                                  csr_we,
   input  logic [biq_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [COEF_BITS-1:0]                  csr_wdata
);
   import biq_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HIST_W = 4 * SAMPLE_BITS;
   localparam logic signed [COEF_BITS-1:0] B0_RESET =
      {{(COEF_BITS-1){1'b0}}, 1'b1} << (COEF_BITS - 2);

   // coefficient registers
   logic signed [COEF_BITS-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff;
   logic signed [COEF_BITS-1:0] coef_a1_ff, coef_a2_ff;

   // history memory, one entry per channel: {y2, y1, x2, x1}
   logic [HIST_W-1:0]   hist_mem [CHANNELS];
   logic [CHANNELS-1:0] hist_vld_ff, hist_vld_in;  // entry written since reset
   logic [HIST_W-1:0]   rd_data_ff;

   // compute stage (the cycle after a sample is taken)
   logic                         s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;
   logic [CH_W-1:0]              s1_ch_ff;
   logic                         s1_zero_ff;      // history reads as zero
   logic                         s1_fwd_ff;       // use forwarded history
   logic [HIST_W-1:0]            s1_fwd_data_ff;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_sat_ff;

   logic                          req_accept;
   logic                          s1_fire;
   logic [CH_W-1:0]               req_ch;
   logic [HIST_W-1:0]             s1_hist;
   logic [HIST_W-1:0]             wb_data;
   logic signed [SAMPLE_BITS-1:0] h_x1, h_x2, h_y1, h_y2;
   logic signed [SAMPLE_BITS-1:0] mac_y;
   logic                          mac_sat;

   // channel index wraps onto the configured channel count
   assign req_ch = (CHANNELS > 1) ? CH_W'(req_channel) : '0;

   // compute stage moves on when the output register is free or draining
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // ---------------------------------------------------------------
   // coefficient writes; unknown indexes are dropped
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= B0_RESET;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_B0:  coef_b0_ff <= csr_wdata;
            CSR_B1:  coef_b1_ff <= csr_wdata;
            CSR_B2:  coef_b2_ff <= csr_wdata;
            CSR_A1:  coef_a1_ff <= csr_wdata;
            CSR_A2:  coef_a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // history select: block start and unwritten entries read as zero,
   // a write-back to the same channel at the read edge is forwarded
   // ---------------------------------------------------------------
   always_comb begin
      if (s1_zero_ff) begin
         s1_hist = '0;
      end else if (s1_fwd_ff) begin
         s1_hist = s1_fwd_data_ff;
      end else begin
         s1_hist = rd_data_ff;
      end
   end

   assign h_x1 = s1_hist[0*SAMPLE_BITS +: SAMPLE_BITS];
   assign h_x2 = s1_hist[1*SAMPLE_BITS +: SAMPLE_BITS];
   assign h_y1 = s1_hist[2*SAMPLE_BITS +: SAMPLE_BITS];
   assign h_y2 = s1_hist[3*SAMPLE_BITS +: SAMPLE_BITS];

   biq_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .x       (s1_x_ff),
      .x1      (h_x1),
      .x2      (h_x2),
      .y1      (h_y1),
      .y2      (h_y2),
      .coef_b0 (coef_b0_ff),
      .coef_b1 (coef_b1_ff),
      .coef_b2 (coef_b2_ff),
      .coef_a1 (coef_a1_ff),
      .coef_a2 (coef_a2_ff),
      .y       (mac_y),
      .sat     (mac_sat)
   );

   // shifted history written back: saturated output enters y1
   assign wb_data = {h_y1, mac_y, h_x1, s1_x_ff};

   // ---------------------------------------------------------------
   // history memory: read on accept, write on compute
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         hist_mem[s1_ch_ff] <= wb_data;
      end
      if (req_accept) begin
         rd_data_ff <= hist_mem[req_ch];
      end
   end

   // ---------------------------------------------------------------
   // control next state
   // ---------------------------------------------------------------
   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (s1_fire) begin
         hist_vld_in[s1_ch_ff] = 1'b1;
      end

      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_vld_ff  <= hist_vld_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_x_ff        <= req_sample_in;
         s1_ch_ff       <= req_ch;
         s1_fwd_ff      <= s1_fire && (s1_ch_ff == req_ch) && !req_block_start;
         s1_zero_ff     <= req_block_start ||
                           (!hist_vld_ff[req_ch] && !(s1_fire && (s1_ch_ff == req_ch)));
         s1_fwd_data_ff <= wb_data;
      end
      if (s1_fire) begin
         rsp_sample_ff <= mac_y;
         rsp_sat_ff    <= mac_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule : biquad_iir_filter_top

[src/biq_checker.sv]
// biq_checker: port-level assertions for the biquad filter top level
// depends on biq_pkg; bound to biquad_iir_filter_top at the end of this file

module biq_checker #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic signed [SAMPLE_BITS-1:0]      req_sample_in,
   input logic                               req_channel,
   input logic                               req_block_start,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   input logic                               rsp_saturated,
   input logic                               csr_we,
   input logic [biq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [COEF_BITS-1:0]               csr_wdata
);
   import biq_pkg::*;

   // a pending result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transaction completed");

   // input back-pressure only comes from a stalled, full output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // a zero sample on cleared history filters to zero without clipping
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_block_start && req_sample_in == '0)
         ##1 (!rsp_valid || rsp_ready)
      |=> rsp_valid && rsp_sample_out == '0 && !rsp_saturated)
      else $error("cleared history did not give a zero result");

endmodule : biq_checker

bind biquad_iir_filter_top biq_checker #(
   .CHANNELS    (CHANNELS),
   .SAMPLE_BITS (SAMPLE_BITS),
   .COEF_BITS   (COEF_BITS)
) u_biq_checker (.*);

[tb/sv/biquad_result_check.sv]
`timescale 1ns / 1ps
// biquad_result_check: follows the sample and result transactions of the biquad filter,
// keeps its own filter state and coefficient copy, and compares every result field
// depends on biq_pkg for the register map

module biquad_result_check #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_in,
   input  logic                               req_channel,
   input  logic                               req_block_start,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   input  logic                               rsp_saturated,
   input  logic                               csr_we,
   input  logic [biq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]               csr_wdata,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked,
   output int                                 clipped
);
   import biq_pkg::*;

   localparam int     FRAC_BITS = COEF_BITS - 2;
   localparam longint OUT_MAX   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint OUT_MIN   = -OUT_MAX - 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          saturated;
   } filtered_sample_type;

   logic signed [COEF_BITS-1:0]   coefs [NUM_REGS];
   logic signed [SAMPLE_BITS-1:0] x_d1 [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] x_d2 [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y_d1 [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y_d2 [CHANNELS];
   filtered_sample_type           expected_outputs [$];
   int                            errors    = 0;
   int                            n_checked = 0;
   int                            n_clipped = 0;

   // exact sum, round half up, saturate; the clipped value feeds back
   function automatic filtered_sample_type filter_sample(input int ch,
                                                         input logic signed [SAMPLE_BITS-1:0] x);
      longint              acc;
      filtered_sample_type res;
      acc = longint'(coefs[CSR_B0]) * longint'(x)
          + longint'(coefs[CSR_B1]) * longint'(x_d1[ch])
          + longint'(coefs[CSR_B2]) * longint'(x_d2[ch])
          - longint'(coefs[CSR_A1]) * longint'(y_d1[ch])
          - longint'(coefs[CSR_A2]) * longint'(y_d2[ch]);
      acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      res.saturated = 1'b0;
      if (acc > OUT_MAX) begin
         acc = OUT_MAX;
         res.saturated = 1'b1;
      end else if (acc < OUT_MIN) begin
         acc = OUT_MIN;
         res.saturated = 1'b1;
      end
      res.sample_out = acc[SAMPLE_BITS-1:0];
      x_d2[ch] = x_d1[ch];
      x_d1[ch] = x;
      y_d2[ch] = y_d1[ch];
      y_d1[ch] = res.sample_out;
      return res;
   endfunction

   always @(posedge clock) begin
      filtered_sample_type want;
      int                  ch;
      if (reset) begin
         foreach (coefs[i]) coefs[i] = '0;
         coefs[CSR_B0] = COEF_BITS'(1) << FRAC_BITS;
         for (int c = 0; c < CHANNELS; c++) begin
            x_d1[c] = '0;
            x_d2[c] = '0;
            y_d1[c] = '0;
            y_d2[c] = '0;
         end
         expected_outputs.delete();
      end else begin
         // writes to indexes past the register map are dropped
         if (csr_we && csr_index < NUM_REGS) coefs[csr_index] = csr_wdata;
         if (req_valid && req_ready) begin
            ch = int'(req_channel) % CHANNELS;
            if (req_block_start) begin
               x_d1[ch] = '0;
               x_d2[ch] = '0;
               y_d1[ch] = '0;
               y_d2[ch] = '0;
            end
            expected_outputs.push_back(filter_sample(ch, req_sample_in));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               errors++;
               $display("%0t: result with no sample outstanding, expected none, got %0d/%0b",
                        $time, rsp_sample_out, rsp_saturated);
            end else begin
               want = expected_outputs.pop_front();
               n_checked++;
               if (want.saturated) n_clipped++;
               if (rsp_sample_out !== want.sample_out) begin
                  errors++;
                  $display("%0t: sample_out mismatch, expected %0d, got %0d",
                           $time, $signed(want.sample_out), rsp_sample_out);
               end
               if (rsp_saturated !== want.saturated) begin
                  errors++;
                  $display("%0t: saturated mismatch, expected %0b, got %0b",
                           $time, want.saturated, rsp_saturated);
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_outputs.size();
      checked    <= n_checked;
      clipped    <= n_clipped;
   end

endmodule : biquad_result_check

[tb/sv/tb_biquad_iir_filter_top.sv]
`timescale 1ns / 1ps
// tb_biquad_iir_filter_top: stimulus, flow control and verdict for the biquad filter
// depends on biq_pkg, biquad_iir_filter_top and biquad_result_check

module tb_biquad_iir_filter_top;
   import biq_pkg::*;

   localparam int  CHANNELS       = 2;
   localparam int  SAMPLE_BITS    = 16;
   localparam int  COEF_BITS      = 16;
   localparam real CLK_PERIOD     = 12.0;
   localparam int  RESET_CYCLES   = 3;
   localparam int  DRAIN_CYCLES   = 6;     // extra settling margin after the last result is taken
   localparam int  WATCHDOG_LIMIT = 1000;  // well above the longest stall or gap
   localparam int  RANDOM_SETS    = 8;
   localparam int  ITEMS_PER_SET  = 75;

   // coefficient corner values, Q2.14
   localparam logic [COEF_BITS-1:0] COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic [COEF_BITS-1:0] COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;
   localparam logic [COEF_BITS-1:0] COEF_HALF = COEF_BITS'(1) << (COEF_BITS - 3);

   // sample corner values, Q1.15
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ZERO = '0;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ONE  = 1;

   // register indexes past the map, writes there must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_FIRST = CSR_INDEX_BITS'(NUM_REGS);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LAST  = '1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_in;
   logic                          req_channel;
   logic                          req_block_start;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_saturated;
   logic                          csr_we;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [COEF_BITS-1:0]          csr_wdata;

   int fail_count;
   int pending;
   int checked;
   int clipped;
   int items_sent  = 0;
   int sets_loaded = 0;
   bit steady_flow = 1'b0;  // when set, neither side inserts gaps or stalls

   always #(CLK_PERIOD / 2) clock = ~clock;

   biquad_iir_filter_top #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .req_channel     (req_channel),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_saturated   (rsp_saturated),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // watches both channels and the coefficient writes, reports a failure count
   biquad_result_check #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .req_channel     (req_channel),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_saturated   (rsp_saturated),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked),
      .clipped         (clipped)
   );

   // idle length: mostly none, often a few cycles, now and then a long one
   function automatic int idle_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // random sample: mostly full range, some low level, some at the rails, zero or minus one
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return SAMPLE_BITS'($urandom);
      if (r < 9) return SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
      case ($urandom_range(0, 3))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_ZERO;
         default: return -SAMPLE_ONE;
      endcase
   endfunction

   function automatic logic [COEF_BITS-1:0] rail_coef();
      return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
   endfunction

   // one sample transaction, then an optional gap with valid low
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic ch,
                              input logic clear_history);
      int gap;
      req_valid       <= 1'b1;
      req_sample_in   <= x;
      req_channel     <= ch;
      req_block_start <= clear_history;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_coef(input logic [CSR_INDEX_BITS-1:0] idx,
                             input logic [COEF_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // full coefficient set; sometimes also pokes an index past the map
   task automatic load_coefs(input logic [COEF_BITS-1:0] b0, input logic [COEF_BITS-1:0] b1,
                             input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] a1,
                             input logic [COEF_BITS-1:0] a2);
      write_coef(CSR_B0, b0);
      write_coef(CSR_B1, b1);
      write_coef(CSR_B2, b2);
      write_coef(CSR_A1, a1);
      write_coef(CSR_A2, a2);
      if ($urandom_range(0, 2) == 0)
         write_coef($urandom_range(0, 1) ? CSR_UNUSED_FIRST : CSR_UNUSED_LAST,
                    COEF_BITS'($urandom));
      csr_we <= 1'b0;
      sets_loaded++;
   endtask

   // quiet the input, wait for every outstanding result, then let the pipe settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side back-pressure: bursts of ready with stalls in between
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         stall = idle_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // watchdog: ends the run after too many cycles without any transaction
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      do @(posedge clock); while (reset);
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // main stimulus
   initial begin
      logic                          ch;
      logic                          clear_history;
      logic [COEF_BITS-1:0]          a2;
      int                            a1_span;
      req_valid       <= 1'b0;
      req_sample_in   <= '0;
      req_channel     <= 1'b0;
      req_block_start <= 1'b0;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients are a pure pass-through: rails and small values on both channels
      send_sample(SAMPLE_MAX, 1'b0, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1, 1'b1);
      send_sample(SAMPLE_ZERO, 1'b0, 1'b0);
      send_sample(-SAMPLE_ONE, 1'b1, 1'b0);
      send_sample(SAMPLE_ONE, 1'b0, 1'b0);
      wait_drained();

      // gain of one half: exact halves round toward plus infinity
      write_coef(CSR_UNUSED_FIRST, COEF_MAX);
      write_coef(CSR_UNUSED_LAST, COEF_MIN);
      load_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
      send_sample(SAMPLE_ONE, 1'b0, 1'b1);
      send_sample(-SAMPLE_ONE, 1'b0, 1'b0);
      send_sample(SAMPLE_BITS'(3 * SAMPLE_ONE), 1'b1, 1'b1);
      send_sample(SAMPLE_BITS'(-3 * SAMPLE_ONE), 1'b1, 1'b0);
      wait_drained();

      // coefficients on the rails: clipping both ways, history clear mid-stream
      load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
      send_sample(SAMPLE_MAX, 1'b0, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1, 1'b1);
      send_sample(SAMPLE_ZERO, 1'b1, 1'b0);
      send_sample(SAMPLE_ZERO, 1'b1, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0, 1'b1);
      wait_drained();

      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
      send_sample(SAMPLE_MIN, 1'b0, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1, 1'b0);
      wait_drained();

      // random part: one coefficient set per round, each drained before the next
      for (int set = 0; set < RANDOM_SETS; set++) begin
         steady_flow <= (set % 4 == 3);
         case (set % 3)
            0: load_coefs(COEF_BITS'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom),
                          COEF_BITS'($urandom), COEF_BITS'($urandom));
            1: begin
               // a stable-looking filter so that the recursion runs for long stretches
               a2      = COEF_BITS'($urandom_range(0, 15000));
               a1_span = 16383 + int'(a2);
               load_coefs(COEF_BITS'(int'($urandom_range(0, 16384)) - 8192),
                          COEF_BITS'(int'($urandom_range(0, 16384)) - 8192),
                          COEF_BITS'(int'($urandom_range(0, 16384)) - 8192),
                          COEF_BITS'(int'($urandom_range(0, 2 * a1_span)) - a1_span),
                          a2);
            end
            default: load_coefs(rail_coef(), rail_coef(), rail_coef(), rail_coef(),
                                rail_coef());
         endcase
         ch = 1'($urandom_range(0, 1));
         for (int i = 0; i < ITEMS_PER_SET; i++) begin
            // runs on one channel mixed with switches, occasional buffer starts
            if ($urandom_range(0, 2) == 0) ch = ~ch;
            clear_history = ($urandom_range(0, 19) == 0);
            send_sample(random_sample(), ch, clear_history);
         end
         wait_drained();
      end

      $display("sent %0d sample transactions under %0d coefficient sets",
               items_sent, sets_loaded);
      $display("compared %0d filtered samples, %0d of them clipped", checked, clipped);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule : tb_biquad_iir_filter_top

[biquad_iir_filter_top.f]
src/biq_pkg.sv
src/biq_mac.sv
src/biquad_iir_filter_top.sv
src/biq_checker.sv
tb/sv/biquad_result_check.sv
tb/sv/tb_biquad_iir_filter_top.sv
